>>> rtl/cnps_pkg.sv
package cnps_pkg;

    // Store geometry
    localparam int MAX_POINTS   = 1024;
    localparam int PT_AW        = 10;
    localparam int CNT_W        = 11;
    localparam int MAX_CLUSTERS = 32;
    localparam int CL_AW        = 5;
    localparam int NC_W         = 6;

    // Arithmetic widths (LSB units of Q16.8)
    localparam int COORD_W = 24;
    localparam int SQ_W    = 48;   // one squared axis difference
    localparam int DS_W    = 50;   // sum of three squares
    localparam int ROOT_W  = 25;   // floor sqrt of DS_W bits
    localparam int REM_W   = 26;   // sqrt partial remainder
    localparam int CEIL_W  = 26;   // ceil sqrt
    localparam int RAD_W   = 25;   // stored sphere radius
    localparam int DMIN_W  = 28;
    localparam int RD_W    = 29;
    localparam int RDSQ_W  = 58;

    // Cluster table word: first, last, center x/y/z, radius
    localparam int CL_W = 2 * PT_AW + 3 * COORD_W + RAD_W;
    localparam int PT_W = 3 * COORD_W;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NOP   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
        logic              inexact;
    } sqrt_res_t;

    typedef struct packed {
        logic             done;
        logic [PT_AW-1:0] quo;
    } div_res_t;

    // Squared difference of two signed coordinates
    function automatic logic [SQ_W-1:0] sq_diff(input logic signed [COORD_W-1:0] a,
                                                input logic signed [COORD_W-1:0] b);
        logic signed [COORD_W:0] d;
        logic [COORD_W-1:0]      m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
        return m * m;
    endfunction

endpackage

>>> rtl/cnps_ram.sv
module cnps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> rtl/cnps_sqrt.sv
// Bit-serial integer square root, one root bit per cycle
module cnps_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [cnps_pkg::DS_W-1:0]    arg,
    output cnps_pkg::sqrt_res_t          res
);

    localparam logic [4:0] LAST = 5'(cnps_pkg::ROOT_W - 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [4:0]                    cnt_reg;
    logic [cnps_pkg::DS_W-1:0]     rad_reg;
    logic [cnps_pkg::REM_W-1:0]    rem_reg;
    logic [cnps_pkg::ROOT_W-1:0]   root_reg;

    logic [cnps_pkg::REM_W+1:0]    rem_s;
    logic [cnps_pkg::REM_W+1:0]    trial;
    logic                          ge;
    logic [cnps_pkg::REM_W-1:0]    rem_next;
    logic [cnps_pkg::ROOT_W-1:0]   root_next;

    // One restoring step
    always_comb
    begin
        rem_s     = {rem_reg, rad_reg[cnps_pkg::DS_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        ge        = rem_s >= trial;
        rem_next  = ge ? cnps_pkg::REM_W'(rem_s - trial) : cnps_pkg::REM_W'(rem_s);
        root_next = {root_reg[cnps_pkg::ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rad_reg  <= arg;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg  <= rem_next;
                root_reg <= root_next;
                rad_reg  <= {rad_reg[cnps_pkg::DS_W-3:0], 2'b00};
                cnt_reg  <= cnt_reg + 5'd1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign res.done    = done_reg;
    assign res.root    = root_reg;
    assign res.inexact = rem_reg != '0;

endmodule

>>> rtl/cnps_div.sv
// Restoring divider, one quotient bit per cycle
module cnps_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cnps_pkg::PT_AW-1:0]  dividend,
    input  logic [cnps_pkg::NC_W-1:0]   divisor,
    output cnps_pkg::div_res_t          res
);

    localparam logic [3:0] LAST = 4'(cnps_pkg::PT_AW - 1);

    logic                         busy_reg;
    logic                         done_reg;
    logic [3:0]                   cnt_reg;
    logic [cnps_pkg::PT_AW-1:0]   dvd_reg;
    logic [cnps_pkg::NC_W-1:0]    dvs_reg;
    logic [cnps_pkg::NC_W-1:0]    rem_reg;
    logic [cnps_pkg::PT_AW-1:0]   quo_reg;

    logic [cnps_pkg::NC_W:0]      rem_s;
    logic                         ge;

    always_comb
    begin
        rem_s = {rem_reg, dvd_reg[cnps_pkg::PT_AW-1]};
        ge    = rem_s >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
                quo_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? cnps_pkg::NC_W'(rem_s - {1'b0, dvs_reg})
                              : cnps_pkg::NC_W'(rem_s);
                quo_reg <= {quo_reg[cnps_pkg::PT_AW-2:0], ge};
                dvd_reg <= {dvd_reg[cnps_pkg::PT_AW-2:0], 1'b0};
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign res.done = done_reg;
    assign res.quo  = quo_reg;

endmodule

>>> rtl/clustered_nearest_point_search.sv
// Channel  | Ports                                          | Handshake
// request  | req_type, coord_x, coord_y, coord_z            | start high, busy low
// result   | nearest_index, status                          | done, one-cycle strobe
//
// Load, clear and no-op words finish in the idle state; the result strobes on the next cycle.
// A query after a store change first rebuilds the cluster spheres, paced by the single point
// RAM port and the 25-step bit-serial square root. The search then takes an initial bound,
// steps past runs off the ends, prunes runs by their spheres, scans the points of each
// remaining run and takes one more root for each run that improves the best distance.
// Reset clears state, result, counts and flags only; memories are read only after being written.
// The result is never held off: done strobes for one cycle.
module clustered_nearest_point_search (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          req_type,
    input  logic signed [cnps_pkg::COORD_W-1:0] coord_x,
    input  logic signed [cnps_pkg::COORD_W-1:0] coord_y,
    input  logic signed [cnps_pkg::COORD_W-1:0] coord_z,
    output logic                                done,
    output logic [cnps_pkg::PT_AW-1:0]          nearest_index,
    output logic [1:0]                          status
);

    typedef enum logic [4:0] {
        S_IDLE, S_NC, S_DIV, S_BK, S_BSCAN, S_BC, S_BSQ, S_BR, S_BRW,
        S_S0, S_SRD, S_S1, S_S2, S_S3, S_LOOP, S_CRD, S_C1, S_C2, S_C3, S_C4,
        S_PSCAN, S_PSQ, S_STEP
    } state_t;

    typedef logic signed [cnps_pkg::COORD_W-1:0] coord_t;

    state_t                          state_reg;
    logic                            done_reg;
    logic [cnps_pkg::PT_AW-1:0]      idx_reg;
    cnps_pkg::status_t               status_reg;

    // Store bookkeeping
    logic [cnps_pkg::CNT_W-1:0]      count_reg;
    logic                            built_reg;
    logic [cnps_pkg::NC_W-1:0]       ncl_reg;
    logic [cnps_pkg::CL_AW-1:0]      last_reg;

    // Query word
    coord_t                          qx_reg, qy_reg, qz_reg;

    // Build state
    logic [cnps_pkg::NC_W-1:0]       nc_reg;
    logic [cnps_pkg::CNT_W-1:0]      per_reg;
    logic [cnps_pkg::NC_W-1:0]       k_reg;
    logic [cnps_pkg::PT_AW-1:0]      f_reg, l_reg;
    logic                            first_reg;
    coord_t                          lox_reg, loy_reg, loz_reg;
    coord_t                          hix_reg, hiy_reg, hiz_reg;
    coord_t                          cx_reg, cy_reg, cz_reg;

    // Scan pipeline
    logic [cnps_pkg::PT_AW-1:0]      i_reg;
    logic                            issued_reg;
    logic                            v1_reg, v2_reg;
    logic [cnps_pkg::PT_AW-1:0]      id1_reg, id2_reg;
    logic [cnps_pkg::SQ_W-1:0]       sqx_reg, sqy_reg, sqz_reg;

    // Search state
    logic [cnps_pkg::CL_AW-1:0]      ic_reg, cj_reg;
    logic [cnps_pkg::PT_AW-1:0]      cf_reg, ce_reg;
    logic [cnps_pkg::RAD_W-1:0]      crad_reg;
    logic [cnps_pkg::DS_W-1:0]       dsq_reg;
    logic [cnps_pkg::DMIN_W-1:0]     dmin_reg;
    logic [cnps_pkg::RD_W-1:0]       rd_reg;
    logic [cnps_pkg::RDSQ_W-1:0]     rdsq_reg;
    logic signed [7:0]               jc_reg, js_reg;
    logic [cnps_pkg::NC_W-1:0]       kc_reg;
    logic                            found_reg, upd_reg;
    logic [cnps_pkg::DS_W-1:0]       dsmin_reg;
    logic [cnps_pkg::PT_AW-1:0]      best_reg;

    // Shared square root unit and the divider
    logic                            sq_start_reg;
    logic [cnps_pkg::DS_W-1:0]       sq_arg_reg;
    cnps_pkg::sqrt_res_t             sq_res;
    logic                            dv_start_reg;
    cnps_pkg::div_res_t              dv_res;
    logic [cnps_pkg::CEIL_W-1:0]     sq_ceil;

    // Memories
    logic                            pt_we;
    logic [cnps_pkg::PT_AW-1:0]      pt_addr;
    logic [cnps_pkg::PT_W-1:0]       pt_rdata;
    logic                            cl_we;
    logic [cnps_pkg::CL_AW-1:0]      cl_addr;
    logic [cnps_pkg::CL_W-1:0]       cl_wdata, cl_rdata;

    // Combinational helpers
    logic                            accept;
    coord_t                          pxd, pyd, pzd;
    coord_t                          ccx, ccy, ccz;
    coord_t                          ax, ay, az, bx, by, bz;
    logic [cnps_pkg::DS_W-1:0]       sq_sum;
    logic [16:0]                     f_full, l_full;
    logic [cnps_pkg::PT_AW-1:0]      n_last;
    logic                            issue;
    logic [cnps_pkg::PT_AW-1:0]      scan_end;
    logic signed [7:0]               js_a, jc_a, js_b, jc_b, js_next, jc_next;
    logic signed [7:0]               ncl_s;
    logic                            jc_ok;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = state_reg != S_IDLE;

    assign {pxd, pyd, pzd} = pt_rdata;
    assign ccx = cl_rdata[cnps_pkg::RAD_W+3*cnps_pkg::COORD_W-1 -: cnps_pkg::COORD_W];
    assign ccy = cl_rdata[cnps_pkg::RAD_W+2*cnps_pkg::COORD_W-1 -: cnps_pkg::COORD_W];
    assign ccz = cl_rdata[cnps_pkg::RAD_W+cnps_pkg::COORD_W-1 -: cnps_pkg::COORD_W];

    assign sq_ceil = cnps_pkg::CEIL_W'(sq_res.root) + cnps_pkg::CEIL_W'(sq_res.inexact);

    // Squarer operand select: run sphere, cluster center, or stored point
    always_comb
    begin
        ax = qx_reg;
        ay = qy_reg;
        az = qz_reg;
        bx = pxd;
        by = pyd;
        bz = pzd;
        if (state_reg == S_S1 || state_reg == S_C1)
        begin
            bx = ccx;
            by = ccy;
            bz = ccz;
        end
        else if (state_reg == S_BSQ)
        begin
            ax = hix_reg;
            ay = hiy_reg;
            az = hiz_reg;
            bx = cx_reg;
            by = cy_reg;
            bz = cz_reg;
        end
    end

    assign sq_sum = cnps_pkg::DS_W'(sqx_reg) + cnps_pkg::DS_W'(sqy_reg)
                  + cnps_pkg::DS_W'(sqz_reg);

    // Run bounds, clamped to the last point
    always_comb
    begin
        n_last = cnps_pkg::PT_AW'(count_reg - cnps_pkg::CNT_W'(1));
        f_full = 17'(k_reg * per_reg);
        l_full = f_full + 17'(per_reg) - 17'd1;
        if (f_full >= 17'(count_reg))
        begin
            f_full = 17'(n_last);
        end
        if (l_full >= 17'(count_reg))
        begin
            l_full = 17'(n_last);
        end
    end

    // Point read issue during the scans
    assign scan_end = (state_reg == S_BSCAN) ? l_reg : ce_reg;
    assign issue    = (state_reg == S_BSCAN || state_reg == S_PSCAN) && !issued_reg;

    always_comb
    begin
        pt_we   = accept && (req_type == cnps_pkg::REQ_LOAD)
               && (count_reg != cnps_pkg::CNT_W'(cnps_pkg::MAX_POINTS));
        pt_addr = (state_reg == S_IDLE) ? count_reg[cnps_pkg::PT_AW-1:0] : i_reg;
    end

    // Cluster table port
    assign cl_we    = (state_reg == S_BRW) && sq_res.done;
    assign cl_addr  = (state_reg == S_BRW) ? k_reg[cnps_pkg::CL_AW-1:0] : cj_reg;
    assign cl_wdata = {f_reg, l_reg, cx_reg, cy_reg, cz_reg,
                       cnps_pkg::RAD_W'(sq_ceil)};

    // Zigzag step over the runs
    always_comb
    begin
        ncl_s   = $signed({2'b00, ncl_reg});
        jc_ok   = (jc_reg >= 8'sd0) && (jc_reg < ncl_s);
        js_a    = (js_reg > 8'sd0) ? -js_reg - 8'sd1 : -js_reg + 8'sd1;
        jc_a    = jc_reg + js_a;
        js_b    = (js_a > 8'sd0) ? -js_a - 8'sd1 : -js_a + 8'sd1;
        jc_b    = jc_a + js_b;
        js_next = js_a;
        jc_next = jc_a;
        if (jc_a < 8'sd0 || jc_a >= ncl_s)
        begin
            js_next = js_b;
            jc_next = jc_b;
        end
    end

    cnps_ram #(
        .WIDTH (cnps_pkg::PT_W),
        .DEPTH (cnps_pkg::MAX_POINTS)
    ) u_pt_ram (
        .clk   (clk),
        .we    (pt_we),
        .addr  (pt_addr),
        .wdata ({coord_x, coord_y, coord_z}),
        .rdata (pt_rdata)
    );

    cnps_ram #(
        .WIDTH (cnps_pkg::CL_W),
        .DEPTH (cnps_pkg::MAX_CLUSTERS)
    ) u_cl_ram (
        .clk   (clk),
        .we    (cl_we),
        .addr  (cl_addr),
        .wdata (cl_wdata),
        .rdata (cl_rdata)
    );

    cnps_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start_reg),
        .arg   (sq_arg_reg),
        .res   (sq_res)
    );

    cnps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start_reg),
        .dividend (n_last),
        .divisor  (nc_reg),
        .res      (dv_res)
    );

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            idx_reg      <= '0;
            status_reg   <= cnps_pkg::ST_OK;
            count_reg    <= '0;
            built_reg    <= 1'b0;
            ncl_reg      <= '0;
            last_reg     <= '0;
            sq_start_reg <= 1'b0;
            dv_start_reg <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
        end
        else
        begin
            done_reg     <= 1'b0;
            sq_start_reg <= 1'b0;
            dv_start_reg <= 1'b0;
            v1_reg       <= issue;
            v2_reg       <= v1_reg;
            id1_reg      <= i_reg;
            id2_reg      <= id1_reg;
            {sqx_reg, sqy_reg, sqz_reg} <= {cnps_pkg::sq_diff(ax, bx),
                                            cnps_pkg::sq_diff(ay, by),
                                            cnps_pkg::sq_diff(az, bz)};
            if (issue)
            begin
                i_reg <= i_reg + cnps_pkg::PT_AW'(1);
                if (i_reg == scan_end)
                begin
                    issued_reg <= 1'b1;
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        qx_reg     <= coord_x;
                        qy_reg     <= coord_y;
                        qz_reg     <= coord_z;
                        idx_reg    <= '0;
                        status_reg <= cnps_pkg::ST_OK;
                        case (req_type)
                            cnps_pkg::REQ_LOAD:
                            begin
                                done_reg <= 1'b1;
                                if (pt_we)
                                begin
                                    count_reg <= count_reg + cnps_pkg::CNT_W'(1);
                                    built_reg <= 1'b0;
                                end
                                else
                                begin
                                    status_reg <= cnps_pkg::ST_FULL;
                                end
                            end
                            cnps_pkg::REQ_QUERY:
                            begin
                                if (count_reg == '0)
                                begin
                                    done_reg   <= 1'b1;
                                    status_reg <= cnps_pkg::ST_EMPTY;
                                end
                                else if (built_reg)
                                begin
                                    state_reg <= S_S0;
                                end
                                else
                                begin
                                    sq_start_reg <= 1'b1;
                                    sq_arg_reg   <= cnps_pkg::DS_W'(count_reg);
                                    state_reg    <= S_NC;
                                end
                            end
                            cnps_pkg::REQ_CLEAR:
                            begin
                                done_reg  <= 1'b1;
                                count_reg <= '0;
                                built_reg <= 1'b0;
                                ncl_reg   <= '0;
                                last_reg  <= '0;
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end

                // Run count and run length
                S_NC:
                begin
                    if (sq_res.done)
                    begin
                        if (sq_res.root > cnps_pkg::ROOT_W'(cnps_pkg::MAX_CLUSTERS))
                        begin
                            nc_reg <= cnps_pkg::NC_W'(cnps_pkg::MAX_CLUSTERS);
                        end
                        else
                        begin
                            nc_reg <= cnps_pkg::NC_W'(sq_res.root);
                        end
                        dv_start_reg <= 1'b1;
                        state_reg    <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (dv_res.done)
                    begin
                        per_reg   <= cnps_pkg::CNT_W'(dv_res.quo) + cnps_pkg::CNT_W'(1);
                        k_reg     <= '0;
                        state_reg <= S_BK;
                    end
                end

                // Bounding box, center and sphere radius of one run
                S_BK:
                begin
                    f_reg      <= cnps_pkg::PT_AW'(f_full);
                    l_reg      <= cnps_pkg::PT_AW'(l_full);
                    i_reg      <= cnps_pkg::PT_AW'(f_full);
                    issued_reg <= 1'b0;
                    first_reg  <= 1'b1;
                    state_reg  <= S_BSCAN;
                end
                S_BSCAN:
                begin
                    if (v1_reg)
                    begin
                        first_reg <= 1'b0;
                        if (first_reg || pxd < lox_reg) lox_reg <= pxd;
                        if (first_reg || pyd < loy_reg) loy_reg <= pyd;
                        if (first_reg || pzd < loz_reg) loz_reg <= pzd;
                        if (first_reg || pxd > hix_reg) hix_reg <= pxd;
                        if (first_reg || pyd > hiy_reg) hiy_reg <= pyd;
                        if (first_reg || pzd > hiz_reg) hiz_reg <= pzd;
                    end
                    else if (issued_reg)
                    begin
                        state_reg <= S_BC;
                    end
                end
                S_BC:
                begin
                    cx_reg    <= coord_t'(({lox_reg[23], lox_reg} + {hix_reg[23], hix_reg}) >>> 1);
                    cy_reg    <= coord_t'(({loy_reg[23], loy_reg} + {hiy_reg[23], hiy_reg}) >>> 1);
                    cz_reg    <= coord_t'(({loz_reg[23], loz_reg} + {hiz_reg[23], hiz_reg}) >>> 1);
                    state_reg <= S_BSQ;
                end
                S_BSQ:
                begin
                    state_reg <= S_BR;
                end
                S_BR:
                begin
                    sq_start_reg <= 1'b1;
                    sq_arg_reg   <= sq_sum;
                    state_reg    <= S_BRW;
                end
                S_BRW:
                begin
                    if (sq_res.done)
                    begin
                        k_reg <= k_reg + cnps_pkg::NC_W'(1);
                        if (k_reg + cnps_pkg::NC_W'(1) == nc_reg)
                        begin
                            ncl_reg   <= nc_reg;
                            last_reg  <= '0;
                            built_reg <= 1'b1;
                            state_reg <= S_S0;
                        end
                        else
                        begin
                            state_reg <= S_BK;
                        end
                    end
                end

                // Initial bound from the last winning run
                S_S0:
                begin
                    if (cnps_pkg::NC_W'(last_reg) < ncl_reg)
                    begin
                        ic_reg <= last_reg;
                        cj_reg <= last_reg;
                    end
                    else
                    begin
                        ic_reg <= '0;
                        cj_reg <= '0;
                    end
                    state_reg <= S_SRD;
                end
                S_SRD:
                begin
                    state_reg <= S_S1;
                end
                S_S1:
                begin
                    {cf_reg, ce_reg} <= cl_rdata[cnps_pkg::CL_W-1 -: 2*cnps_pkg::PT_AW];
                    crad_reg  <= cl_rdata[cnps_pkg::RAD_W-1:0];
                    state_reg <= S_S2;
                end
                S_S2:
                begin
                    sq_start_reg <= 1'b1;
                    sq_arg_reg   <= sq_sum;
                    state_reg    <= S_S3;
                end
                S_S3:
                begin
                    if (sq_res.done)
                    begin
                        dmin_reg  <= cnps_pkg::DMIN_W'((cnps_pkg::DMIN_W'(sq_ceil)
                                     + cnps_pkg::DMIN_W'(crad_reg)) << 1);
                        jc_reg    <= $signed({3'b000, ic_reg});
                        js_reg    <= '0;
                        kc_reg    <= '0;
                        found_reg <= 1'b0;
                        best_reg  <= '0;
                        state_reg <= S_LOOP;
                    end
                end

                // Zigzag walk over the runs
                S_LOOP:
                begin
                    if (kc_reg == ncl_reg)
                    begin
                        done_reg   <= 1'b1;
                        idx_reg    <= best_reg;
                        status_reg <= cnps_pkg::ST_OK;
                        last_reg   <= ic_reg;
                        state_reg  <= S_IDLE;
                    end
                    else if (jc_ok)
                    begin
                        cj_reg    <= cnps_pkg::CL_AW'(jc_reg);
                        state_reg <= S_CRD;
                    end
                    else
                    begin
                        state_reg <= S_STEP;
                    end
                end
                S_CRD:
                begin
                    state_reg <= S_C1;
                end
                S_C1:
                begin
                    {cf_reg, ce_reg} <= cl_rdata[cnps_pkg::CL_W-1 -: 2*cnps_pkg::PT_AW];
                    crad_reg  <= cl_rdata[cnps_pkg::RAD_W-1:0];
                    state_reg <= S_C2;
                end
                S_C2:
                begin
                    dsq_reg   <= sq_sum;
                    rd_reg    <= cnps_pkg::RD_W'(crad_reg) + cnps_pkg::RD_W'(dmin_reg);
                    state_reg <= S_C3;
                end
                S_C3:
                begin
                    rdsq_reg  <= rd_reg * rd_reg;
                    state_reg <= S_C4;
                end
                S_C4:
                begin
                    if (cnps_pkg::RDSQ_W'(dsq_reg) <= rdsq_reg)
                    begin
                        i_reg      <= cf_reg;
                        issued_reg <= 1'b0;
                        upd_reg    <= 1'b0;
                        state_reg  <= S_PSCAN;
                    end
                    else
                    begin
                        state_reg <= S_STEP;
                    end
                end

                // Point scan of one run
                S_PSCAN:
                begin
                    if (v2_reg)
                    begin
                        if (!found_reg || sq_sum < dsmin_reg)
                        begin
                            found_reg <= 1'b1;
                            dsmin_reg <= sq_sum;
                            best_reg  <= id2_reg;
                            upd_reg   <= 1'b1;
                        end
                    end
                    else if (issued_reg && !v1_reg)
                    begin
                        if (upd_reg)
                        begin
                            sq_start_reg <= 1'b1;
                            sq_arg_reg   <= dsmin_reg;
                            state_reg    <= S_PSQ;
                        end
                        else
                        begin
                            state_reg <= S_STEP;
                        end
                    end
                end
                S_PSQ:
                begin
                    if (sq_res.done)
                    begin
                        dmin_reg  <= cnps_pkg::DMIN_W'(sq_ceil);
                        ic_reg    <= cnps_pkg::CL_AW'(jc_reg);
                        state_reg <= S_STEP;
                    end
                end
                S_STEP:
                begin
                    js_reg    <= js_next;
                    jc_reg    <= jc_next;
                    kc_reg    <= kc_reg + cnps_pkg::NC_W'(1);
                    state_reg <= S_LOOP;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done          = done_reg;
    assign nearest_index = idx_reg;
    assign status        = status_reg;

endmodule

>>> tb/sv/clustered_nearest_point_search_tb.sv
module clustered_nearest_point_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RESET_CYCLES = 8;
    localparam int  RANDOM_WORDS = 500;
    localparam longint CYCLE_LIMIT = 40000000;

    typedef logic signed [cnps_pkg::COORD_W-1:0] coord_t;

    typedef struct {
        logic [cnps_pkg::PT_AW-1:0] index;
        cnps_pkg::status_t          status;
    } answer_t;

    // Point store predictor plus queue of pending answers
    class nearest_point_tracker;
        longint          px[cnps_pkg::MAX_POINTS], py[cnps_pkg::MAX_POINTS];
        longint          pz[cnps_pkg::MAX_POINTS];
        int              npoints;
        bit              spheres_valid;
        int              nruns;
        int              run_first[cnps_pkg::MAX_CLUSTERS];
        int              run_last[cnps_pkg::MAX_CLUSTERS];
        longint          cx[cnps_pkg::MAX_CLUSTERS], cy[cnps_pkg::MAX_CLUSTERS];
        longint          cz[cnps_pkg::MAX_CLUSTERS];
        longint unsigned crad[cnps_pkg::MAX_CLUSTERS];
        int              last_win;
        answer_t         pending[$];
        int              mismatches;

        function new();
            npoints = 0;
            spheres_valid = 0;
            nruns = 0;
            last_win = 0;
            mismatches = 0;
        endfunction

        static function longint unsigned root_floor(longint unsigned v);
            longint unsigned res, bit_w;
            res = 0;
            bit_w = 64'd1 << 62;
            while (bit_w > v)
                bit_w = bit_w >> 2;
            while (bit_w != 0)
            begin
                if (v >= res + bit_w)
                begin
                    v = v - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end
                else
                    res = res >> 1;
                bit_w = bit_w >> 2;
            end
            return res;
        endfunction

        static function longint unsigned root_ceil(longint unsigned v);
            longint unsigned r;
            r = root_floor(v);
            if (r * r < v)
                r++;
            return r;
        endfunction

        static function longint unsigned sqd(longint a, longint b);
            longint d;
            d = a - b;
            if (d < 0)
                d = -d;
            return d * d;
        endfunction

        static function longint half_down(longint s);
            return (s >= 0) ? s / 2 : -((-s + 1) / 2);
        endfunction

        function longint unsigned dist_to_point(int i, longint x, longint y, longint z);
            return sqd(x, px[i]) + sqd(y, py[i]) + sqd(z, pz[i]);
        endfunction

        function longint unsigned dist_to_center(int k, longint x, longint y, longint z);
            return sqd(x, cx[k]) + sqd(y, cy[k]) + sqd(z, cz[k]);
        endfunction

        // Split the store into runs and bound each with a sphere
        function void build_spheres();
            int     per, f, l;
            longint lo[3], hi[3], v[3];
            longint unsigned r2;
            nruns = int'(root_floor(npoints));
            if (nruns > cnps_pkg::MAX_CLUSTERS)
                nruns = cnps_pkg::MAX_CLUSTERS;
            if (nruns == 0)
                nruns = 1;
            per = 1 + (npoints - 1) / nruns;
            for (int k = 0; k < nruns; k++)
            begin
                f = k * per;
                l = f + per - 1;
                if (f >= npoints)
                    f = npoints - 1;
                if (l >= npoints)
                    l = npoints - 1;
                lo[0] = px[f]; lo[1] = py[f]; lo[2] = pz[f];
                hi = lo;
                for (int i = f + 1; i <= l; i++)
                begin
                    v[0] = px[i]; v[1] = py[i]; v[2] = pz[i];
                    for (int a = 0; a < 3; a++)
                    begin
                        if (v[a] < lo[a]) lo[a] = v[a];
                        if (v[a] > hi[a]) hi[a] = v[a];
                    end
                end
                cx[k] = half_down(lo[0] + hi[0]);
                cy[k] = half_down(lo[1] + hi[1]);
                cz[k] = half_down(lo[2] + hi[2]);
                r2 = sqd(hi[0], cx[k]) + sqd(hi[1], cy[k]) + sqd(hi[2], cz[k]);
                run_first[k] = f;
                run_last[k] = l;
                crad[k] = root_ceil(r2);
            end
            last_win = 0;
            spheres_valid = 1;
        endfunction

        // Zigzag pruned search starting from the last winning run
        function int search(longint x, longint y, longint z);
            int              ic, jc, js, best;
            bit              found, improved;
            longint unsigned dmin, dsmin, rd, ds;
            ic = last_win;
            best = 0;
            found = 0;
            dsmin = 0;
            js = 0;
            if (ic >= nruns)
                ic = 0;
            dmin = 2 * (root_ceil(dist_to_center(ic, x, y, z)) + crad[ic]);
            jc = ic;
            for (int kc = 0; kc < nruns; kc++)
            begin
                if (jc >= 0 && jc < nruns)
                begin
                    rd = crad[jc] + dmin;
                    if (dist_to_center(jc, x, y, z) <= rd * rd)
                    begin
                        improved = 0;
                        for (int i = run_first[jc]; i <= run_last[jc]; i++)
                        begin
                            ds = dist_to_point(i, x, y, z);
                            if (!found || ds < dsmin)
                            begin
                                found = 1;
                                dsmin = ds;
                                best = i;
                                improved = 1;
                            end
                        end
                        if (improved)
                        begin
                            dmin = root_ceil(dsmin);
                            ic = jc;
                        end
                    end
                end
                js = (js > 0) ? -js - 1 : -js + 1;
                jc += js;
                if (jc < 0 || jc >= nruns)
                begin
                    js = (js > 0) ? -js - 1 : -js + 1;
                    jc += js;
                end
            end
            last_win = ic;
            return best;
        endfunction

        // Accepted request word: update the model and queue its answer
        function void note_word(cnps_pkg::req_t req, coord_t x, coord_t y, coord_t z);
            answer_t a;
            a.index = '0;
            a.status = cnps_pkg::ST_OK;
            case (req)
                cnps_pkg::REQ_LOAD:
                begin
                    if (npoints >= cnps_pkg::MAX_POINTS)
                        a.status = cnps_pkg::ST_FULL;
                    else
                    begin
                        px[npoints] = longint'(x);
                        py[npoints] = longint'(y);
                        pz[npoints] = longint'(z);
                        npoints++;
                        spheres_valid = 0;
                    end
                end
                cnps_pkg::REQ_QUERY:
                begin
                    if (npoints == 0)
                        a.status = cnps_pkg::ST_EMPTY;
                    else
                    begin
                        if (!spheres_valid)
                            build_spheres();
                        a.index = cnps_pkg::PT_AW'(search(longint'(x), longint'(y),
                                                          longint'(z)));
                    end
                end
                cnps_pkg::REQ_CLEAR:
                begin
                    npoints = 0;
                    spheres_valid = 0;
                    nruns = 0;
                    last_win = 0;
                end
                default: ;
            endcase
            pending.push_back(a);
        endfunction

        // Result word from the block against the oldest pending answer
        function void check_word(logic [cnps_pkg::PT_AW-1:0] index, logic [1:0] status);
            answer_t a;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: index %0d status %0d", index, status);
                return;
            end
            a = pending.pop_front();
            if (index !== a.index || status !== a.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: index %0d status %0d, expected %0d / %0d",
                             index, status, a.index, a.status);
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [1:0]                 req_type;
    coord_t                     coord_x, coord_y, coord_z;
    logic                       done;
    logic [cnps_pkg::PT_AW-1:0] nearest_index;
    logic [1:0]                 status;

    nearest_point_tracker tracker;
    longint           cycles;
    bit               calm;
    coord_t           walk_x, walk_y, walk_z;

    clustered_nearest_point_search dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_z       (coord_z),
        .done          (done),
        .nearest_index (nearest_index),
        .status        (status)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("clustered_nearest_point_search_tb failed");
            $finish;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_word(nearest_index, status);
    end

    // Send one request word; start stays high into the next word unless idling
    task automatic send_word(cnps_pkg::req_t req, coord_t x, coord_t y, coord_t z);
        while (!calm && $urandom_range(0, 99) < 14)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start    <= 1'b1;
        req_type <= req;
        coord_x  <= x;
        coord_y  <= y;
        coord_z  <= z;
        do
            @(posedge clk);
        while (busy);
        tracker.note_word(req, x, y, z);
        @(negedge clk);
    endtask

    function automatic coord_t any_coord();
        return coord_t'($urandom());
    endfunction

    // Next point on a wandering path, occasionally a jump anywhere
    task automatic send_path_point();
        if ($urandom_range(0, 9) == 0)
        begin
            walk_x = any_coord();
            walk_y = any_coord();
            walk_z = any_coord();
        end
        else
        begin
            walk_x = walk_x + coord_t'(int'($urandom_range(0, 4095)) - 2048);
            walk_y = walk_y + coord_t'(int'($urandom_range(0, 4095)) - 2048);
            walk_z = walk_z + coord_t'(int'($urandom_range(0, 255)) - 128);
        end
        send_word(cnps_pkg::REQ_LOAD, walk_x, walk_y, walk_z);
    endtask

    // Query near the path or anywhere
    task automatic send_query();
        if ($urandom_range(0, 3) == 0)
            send_word(cnps_pkg::REQ_QUERY, any_coord(), any_coord(), any_coord());
        else
            send_word(cnps_pkg::REQ_QUERY,
                      walk_x + coord_t'(int'($urandom_range(0, 16383)) - 8192),
                      walk_y + coord_t'(int'($urandom_range(0, 16383)) - 8192),
                      walk_z + coord_t'(int'($urandom_range(0, 1023)) - 512));
    endtask

    localparam coord_t CMAX = {1'b0, {(cnps_pkg::COORD_W-1){1'b1}}};
    localparam coord_t CMIN = {1'b1, {(cnps_pkg::COORD_W-1){1'b0}}};

    initial
    begin
        int pick;
        tracker  = new();
        calm     = 0;
        walk_x   = '0;
        walk_y   = '0;
        walk_z   = '0;
        rst_n    = 1'b0;
        start    = 1'b0;
        req_type = cnps_pkg::REQ_NOP;
        coord_x  = '0;
        coord_y  = '0;
        coord_z  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty store, extremes, ties, no-op, clear
        send_word(cnps_pkg::REQ_QUERY, '0, '0, '0);
        send_word(cnps_pkg::REQ_NOP, CMAX, CMIN, CMAX);
        send_word(cnps_pkg::REQ_LOAD, CMAX, CMAX, CMAX);
        send_word(cnps_pkg::REQ_QUERY, CMAX, CMAX, CMAX);
        send_word(cnps_pkg::REQ_LOAD, CMIN, CMIN, CMIN);
        send_word(cnps_pkg::REQ_QUERY, CMIN, CMIN, CMIN);
        send_word(cnps_pkg::REQ_QUERY, '0, '0, '0);
        send_word(cnps_pkg::REQ_LOAD, CMAX, CMIN, '0);
        send_word(cnps_pkg::REQ_LOAD, CMAX, CMAX, CMAX);
        send_word(cnps_pkg::REQ_LOAD, '0, '0, '0);
        send_word(cnps_pkg::REQ_QUERY, CMAX, CMAX, CMAX);
        send_word(cnps_pkg::REQ_QUERY, CMIN, CMAX, CMIN);
        send_word(cnps_pkg::REQ_QUERY, '0, '0, '0);
        send_word(cnps_pkg::REQ_CLEAR, '0, '0, '0);
        send_word(cnps_pkg::REQ_QUERY, '0, '0, '0);
        for (int i = 0; i < 5; i++)
            send_word(cnps_pkg::REQ_LOAD, coord_t'(100), coord_t'(-100), coord_t'(7));
        send_word(cnps_pkg::REQ_QUERY, coord_t'(100), coord_t'(-100), coord_t'(7));
        send_word(cnps_pkg::REQ_NOP, '0, '0, '0);

        // Random: path loads, queries, occasional clears, no-ops and loads anywhere
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            calm = (n >= 200 && n < 280);
            pick = $urandom_range(0, 99);
            if (pick < 50)
                send_path_point();
            else if (pick < 88)
                send_query();
            else if (pick < 94)
                send_word(cnps_pkg::REQ_CLEAR, any_coord(), any_coord(), any_coord());
            else if (pick < 97)
                send_word(cnps_pkg::REQ_NOP, any_coord(), any_coord(), any_coord());
            else
                send_word(cnps_pkg::REQ_LOAD, any_coord(), any_coord(), any_coord());
        end
        calm = 0;

        // Short fresh path, queries, then clear and query the empty store
        send_word(cnps_pkg::REQ_CLEAR, '0, '0, '0);
        for (int i = 0; i < 8; i++)
            send_path_point();
        for (int i = 0; i < 4; i++)
            send_query();
        send_word(cnps_pkg::REQ_QUERY, CMIN, CMIN, CMIN);
        send_word(cnps_pkg::REQ_CLEAR, '0, '0, '0);
        send_word(cnps_pkg::REQ_QUERY, '0, '0, '0);

        start <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("clustered_nearest_point_search_tb passed");
        else
            $display("clustered_nearest_point_search_tb failed");
        $finish;
    end

endmodule
